// ===== sv/iqdc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqdc_pkg
// Shared types and constants for the 24-bit I/Q unpacker and DC blocker.
// ----------------------------------------------------------------------------
package iqdc_pkg;

  localparam int RAW_W   = 24;
  localparam int OUT_W   = 32;
  localparam int COEF_W  = 24;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 24;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STOPPED = 2'd1;

  localparam logic [COEF_W-1:0] ALPHA_RESET = 24'd16770505;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } iq_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] i_out;
    logic signed [OUT_W-1:0] q_out;
  } iq_out_t;

  // one assembled complex sample, raw two's complement channels
  typedef struct packed {
    logic [RAW_W-1:0] i_raw;
    logic [RAW_W-1:0] q_raw;
  } sample_t;

endpackage
`default_nettype wire

// ===== sv/iqdc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqdc_fifo
// Small register-based queue with full and empty flags.
// ----------------------------------------------------------------------------
module iqdc_fifo #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  full,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/iqdc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqdc_front
// Byte assembler: collects six stream bytes into one raw I/Q sample.
// ----------------------------------------------------------------------------
module iqdc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire iqdc_pkg::iq_in_t in_item,
  input  wire logic             stopped,
  input  wire logic             sq_full,
  output logic                  full,
  output logic                  sq_push,
  output iqdc_pkg::sample_t     sq_data
);
  import iqdc_pkg::*;

  logic [2:0]  pos;
  logic [39:0] hold;
  logic [2:0]  pos_next;
  logic [39:0] hold_next;
  logic        take;

  // only the sixth byte needs room in the sample queue
  assign full    = (pos == 3'd5) && sq_full;
  assign take    = accept && !stopped;
  assign sq_push = take && (pos == 3'd5);
  assign sq_data = '{i_raw: hold[23:0], q_raw: {in_item.data_byte, hold[39:24]}};

  always_comb begin
    pos_next  = pos;
    hold_next = hold;
    if (take) begin
      if (pos == 3'd5 || in_item.last_byte) begin
        pos_next  = '0;
        hold_next = '0;
      end else begin
        pos_next = pos + 1'b1;
        case (pos)
          3'd0:    hold_next[7:0]   = in_item.data_byte;
          3'd1:    hold_next[15:8]  = in_item.data_byte;
          3'd2:    hold_next[23:16] = in_item.data_byte;
          3'd3:    hold_next[31:24] = in_item.data_byte;
          3'd4:    hold_next[39:32] = in_item.data_byte;
          default: hold_next = hold;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      hold <= '0;
    end else begin
      pos  <= pos_next;
      hold <= hold_next;
    end
  end

endmodule
`default_nettype wire

// ===== sv/iqdc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iqdc_back
// Two-stage DC blocker for both channels: multiply, then round/add/saturate.
// ----------------------------------------------------------------------------
module iqdc_back #(
  parameter int ACC_WIDTH      = 32,
  parameter int COEF_FRAC_BITS = 24
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic [iqdc_pkg::COEF_W-1:0]     alpha,
  input  wire logic                            s_valid,
  input  wire iqdc_pkg::sample_t               s_data,
  output logic                                 s_pop,
  input  wire logic                            o_full,
  output logic                                 o_push,
  output iqdc_pkg::iq_out_t                    o_data
);
  import iqdc_pkg::*;

  localparam int F       = COEF_FRAC_BITS;
  localparam int SHL     = (F >= COEF_W) ? F - COEF_W : 0;
  localparam int SHR     = (F < COEF_W) ? COEF_W - F : 0;
  localparam int PW      = F + OUT_W + 1;
  localparam int XW      = 28;
  localparam int SW      = 35;
  localparam int SAT     = (ACC_WIDTH > OUT_W) ? OUT_W : ACC_WIDTH;
  localparam logic signed [PW-1:0] ROUND = PW'(longint'(1) << (F - 1));
  localparam logic signed [SW-1:0] SAT_MAX = SW'((longint'(1) << (SAT - 1)) - 1);
  localparam logic signed [SW-1:0] SAT_MIN = ~SAT_MAX;
  localparam logic signed [XW-1:0] X_OFS = XW'(longint'(1) << 23);

  logic [F-1:0]             coef;
  logic                     busy;
  logic                     issue;
  logic signed [XW-1:0]     xi, xq, xi_next, xq_next;
  logic signed [XW-1:0]     prev_xi, prev_xq;
  logic signed [OUT_W-1:0]  prev_yi, prev_yq;
  logic signed [PW-1:0]     prod_i, prod_q, prod_i_next, prod_q_next;
  logic signed [PW-1:0]     rnd_i, rnd_q;
  logic signed [SW-1:0]     sum_i, sum_q, sat_i, sat_q;

  // realign Q0.24 alpha to F fraction bits
  assign coef = F'(((F + COEF_W)'(alpha) << SHL) >> SHR);

  // one sample in flight; output queue space checked before issue
  assign issue = s_valid && !busy && !o_full;
  assign s_pop = issue;

  always_comb begin
    // x = 4*s - 2^23
    xi_next = $signed({{2{s_data.i_raw[RAW_W-1]}}, s_data.i_raw, 2'b00}) - X_OFS;
    xq_next = $signed({{2{s_data.q_raw[RAW_W-1]}}, s_data.q_raw, 2'b00}) - X_OFS;
    prod_i_next = $signed({1'b0, coef}) * prev_yi;
    prod_q_next = $signed({1'b0, coef}) * prev_yq;
  end

  always_comb begin
    rnd_i = (prod_i + ROUND) >>> F;
    rnd_q = (prod_q + ROUND) >>> F;
    sum_i = SW'(xi) - SW'(prev_xi) + SW'(rnd_i);
    sum_q = SW'(xq) - SW'(prev_xq) + SW'(rnd_q);
    sat_i = (sum_i > SAT_MAX) ? SAT_MAX : ((sum_i < SAT_MIN) ? SAT_MIN : sum_i);
    sat_q = (sum_q > SAT_MAX) ? SAT_MAX : ((sum_q < SAT_MIN) ? SAT_MIN : sum_q);
  end

  assign o_push = busy;
  assign o_data = '{i_out: OUT_W'(sat_i), q_out: OUT_W'(sat_q)};

  always_ff @(posedge clk) begin
    if (issue) begin
      xi     <= xi_next;
      xq     <= xq_next;
      prod_i <= prod_i_next;
      prod_q <= prod_q_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      prev_xi <= '0;
      prev_xq <= '0;
      prev_yi <= '0;
      prev_yq <= '0;
    end else begin
      busy <= issue;
      if (busy) begin
        prev_xi <= xi;
        prev_xq <= xq;
        prev_yi <= OUT_W'(sat_i);
        prev_yq <= OUT_W'(sat_q);
      end
    end
  end

endmodule
`default_nettype wire

// ===== sv/iq24_unpack_dc_block.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iq24_unpack_dc_block
// Unpacks a byte stream of 24-bit little-endian I/Q samples and runs each
// channel through a first-order DC blocker, y = x - x_prev + alpha*y_prev.
// ----------------------------------------------------------------------------
//
// Channel   Handshake            Payload                Notes
// input     push / full          in_data (iq_in_t)      one stream byte per item
// result    empty / pop          out_data (iq_out_t)    one item per six bytes
// config    cfg_valid/cfg_ready  cfg_index, cfg_data    0: alpha, 1: stopped
//
// Cycles: one byte per cycle is taken while full is low. A complete sample
//   goes through the sample queue and then the filter stages (product stage, then
//   round/add/saturate); the y_prev feedback loop keeps one sample in the
//   filter, so a new sample is taken only once the last result is pushed.
// Reset: synchronous; alpha returns to 0.9996, stopped to 0, filter history,
//   byte position and both queues are cleared at once.
// Stalls: full rises only on a sample's sixth byte while the sample queue is
//   full; a stalled pop backs up the result queue, then the sample queue.
// ----------------------------------------------------------------------------
module iq24_unpack_dc_block #(
  parameter int ACC_WIDTH      = 32,
  parameter int COEF_FRAC_BITS = 24,
  parameter int SQ_DEPTH       = 2,
  parameter int OQ_DEPTH       = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output logic                                  full,
  input  wire iqdc_pkg::iq_in_t                 in_data,
  output logic                                  empty,
  input  wire logic                             pop,
  output iqdc_pkg::iq_out_t                     out_data,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [iqdc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [iqdc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import iqdc_pkg::*;

  localparam int SW_BITS = $bits(sample_t);
  localparam int OW_BITS = $bits(iq_out_t);

  // configuration registers
  logic [COEF_W-1:0] alpha;
  logic              stopped;

  // front to sample queue
  logic    in_acc;
  logic    sq_push;
  logic    sq_full;
  logic    sq_empty;
  logic    sq_pop;
  sample_t sq_wdata;
  sample_t sq_rdata;

  // back to result queue
  logic    oq_push;
  logic    oq_full;
  iq_out_t oq_wdata;

  assign cfg_ready = 1'b1;
  assign in_acc    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha   <= ALPHA_RESET;
      stopped <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA:   alpha   <= cfg_data[COEF_W-1:0];
        REG_STOPPED: stopped <= cfg_data[0];
        default:     ;  // unmapped index, write dropped
      endcase
    end
  end

  iqdc_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (in_acc),
    .in_item (in_data),
    .stopped (stopped),
    .sq_full (sq_full),
    .full    (full),
    .sq_push (sq_push),
    .sq_data (sq_wdata)
  );

  iqdc_fifo #(
    .WIDTH (SW_BITS),
    .DEPTH (SQ_DEPTH)
  ) u_sample_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (sq_push),
    .wr_data (sq_wdata),
    .rd_en   (sq_pop),
    .rd_data (sq_rdata),
    .full    (sq_full),
    .empty   (sq_empty)
  );

  iqdc_back #(
    .ACC_WIDTH      (ACC_WIDTH),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .alpha   (alpha),
    .s_valid (!sq_empty),
    .s_data  (sq_rdata),
    .s_pop   (sq_pop),
    .o_full  (oq_full),
    .o_push  (oq_push),
    .o_data  (oq_wdata)
  );

  iqdc_fifo #(
    .WIDTH (OW_BITS),
    .DEPTH (OQ_DEPTH)
  ) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (oq_push),
    .wr_data (oq_wdata),
    .rd_en   (pop && !empty),
    .rd_data (out_data),
    .full    (oq_full),
    .empty   (empty)
  );

  // no sample written into a full sample queue
  a_sq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    sq_push |-> !sq_full)
    else $error("sample queue overflow");

  // no result written into a full result queue
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    oq_push |-> !oq_full)
    else $error("result queue overflow");

  // every sample taken by the filter yields a result in the next cycle
  a_issue_then_push: assert property (@(posedge clk) disable iff (rst)
    sq_pop |=> oq_push)
    else $error("filter dropped a sample");

  // while stopped no sample is assembled
  a_stopped_quiet: assert property (@(posedge clk) disable iff (rst)
    stopped |-> !sq_push)
    else $error("sample assembled while stopped");

endmodule
`default_nettype wire

// ===== tb/tb_iq24_unpack_dc_block.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iq24_unpack_dc_block
// Self-checking bench for the 24-bit I/Q byte unpacker with per-channel DC
// blockers. Bytes go in through the push/full queue port; every accepted byte
// is also run through a local bit-exact model of the unpacker and filters,
// and each I/Q item popped from the block is compared with the oldest
// predicted item. Directed cases hit field extremes, end-of-buffer marks and
// the stopped mode; random streams then run at three alpha settings with
// the sender and receiver stalling at different rates.
// ----------------------------------------------------------------------------
module tb_iq24_unpack_dc_block;
  import iqdc_pkg::*;

  localparam int ACC_WIDTH      = 32;
  localparam int COEF_FRAC_BITS = 24;
  localparam int SAT_W          = (ACC_WIDTH > 32) ? 32 : ACC_WIDTH;
  // idle wait after draining; covers the filter stages and the queue hops
  localparam int IDLE_CYCLES    = 8;
  // longest legal silence is a receiver stall streak plus an idle wait
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int STREAM_BYTES   = 410;

  // DUT ports; the inputs are driven to known values from time zero
  logic      clk;
  logic      rst       = 1'b1;
  logic      push      = 1'b0;
  logic      full;
  iq_in_t    in_data   = '0;
  logic      empty;
  logic      pop       = 1'b0;
  iq_out_t   out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // stall rates in percent of cycles
  int send_idle_pct = 0;
  int recv_idle_pct = 0;

  // local copy of the block's registers and filter history
  logic [COEF_W-1:0] m_alpha   = ALPHA_RESET;
  logic              m_stopped = 1'b0;
  logic [2:0]        m_pos     = '0;
  logic [39:0]       m_hold    = '0;
  longint            prev_i_x  = 0;
  longint            prev_q_x  = 0;
  longint            prev_i_y  = 0;
  longint            prev_q_y  = 0;

  iq_out_t expected_iq[$];
  iq_out_t want;

  int err_count       = 0;
  int stream_bytes    = 0;
  int stopped_bytes   = 0;
  int dropped_samples = 0;
  int items_checked   = 0;
  int cfg_writes      = 0;
  int stall_cycles    = 0;

  iq24_unpack_dc_block #(
    .ACC_WIDTH(ACC_WIDTH),
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .in_data(in_data),
    .empty(empty),
    .pop(pop),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Model of the datapath
  // --------------------------------------------------------------------------

  // raw two's complement 24-bit channel -> x = 4*s - 2^23 (Q.23)
  function automatic longint to_q23(input logic [23:0] raw);
    longint s;
    s = $signed(raw);
    return 4 * s - (longint'(1) << 23);
  endfunction

  // one DC blocker update: y = x - x_prev + round(alpha * y_prev), saturated
  function automatic longint dc_filter(input longint x, input longint x_prev,
                                       input longint y_prev);
    longint coef, prod, p, y, lim;
    // alpha arrives as Q0.24; realign to the block's coefficient fraction
    if (COEF_FRAC_BITS >= 24)
      coef = longint'(m_alpha) << (COEF_FRAC_BITS >= 24 ? COEF_FRAC_BITS - 24 : 0);
    else
      coef = longint'(m_alpha) >> (COEF_FRAC_BITS < 24 ? 24 - COEF_FRAC_BITS : 0);
    prod = coef * y_prev;
    // round half up: add half an LSB, then floor via arithmetic shift
    p = (prod + (longint'(1) << (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
    y = x - x_prev + p;
    lim = longint'(1) << (SAT_W - 1);
    if (y > lim - 1)
      y = lim - 1;
    else if (y < -lim)
      y = -lim;
    return y;
  endfunction

  // advance the model by one accepted byte; a sixth byte queues an I/Q item
  task automatic unpack_filter_byte(input logic [7:0] b, input logic l);
    logic [23:0] q_raw;
    longint xi, xq, yi, yq;
    iq_out_t res;
    if (m_stopped) begin
      // byte and its end mark are both dropped, nothing moves
      stopped_bytes++;
      return;
    end
    stream_bytes++;
    if (m_pos < 5) begin
      m_hold[8*m_pos +: 8] = b;
      m_pos++;
      if (l) begin
        // end of buffer in mid-sample: the partial sample is lost
        m_pos  = '0;
        m_hold = '0;
        dropped_samples++;
      end
      return;
    end
    // sixth byte completes the sample even if it carries the end mark
    q_raw = {b, m_hold[39:24]};
    xi = to_q23(m_hold[23:0]);
    xq = to_q23(q_raw);
    yi = dc_filter(xi, prev_i_x, prev_i_y);
    yq = dc_filter(xq, prev_q_x, prev_q_y);
    prev_i_x = xi;
    prev_i_y = yi;
    prev_q_x = xq;
    prev_q_y = yq;
    m_pos  = '0;
    m_hold = '0;
    res.i_out = yi[31:0];
    res.q_out = yq[31:0];
    expected_iq.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= 40)
      $display("%0t ns MISMATCH: %s", $realtime, msg);
  endtask

  // receiver: random pop, compare each popped item with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (expected_iq.size() == 0) begin
          report_mismatch($sformatf("unexpected item i=%0d q=%0d",
                                    $signed(out_data.i_out), $signed(out_data.q_out)));
        end else begin
          want = expected_iq.pop_front();
          items_checked++;
          if (out_data.i_out !== want.i_out)
            report_mismatch($sformatf("item %0d i_out got %0d want %0d", items_checked,
                                      $signed(out_data.i_out), $signed(want.i_out)));
          if (out_data.q_out !== want.q_out)
            report_mismatch($sformatf("item %0d q_out got %0d want %0d", items_checked,
                                      $signed(out_data.q_out), $signed(want.q_out)));
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: any handshake on any channel clears the count
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------

  // push one byte; push stays high on return so back-to-back bytes stream
  task automatic send_byte(input logic [7:0] b, input logic l);
    iq_in_t item;
    item.data_byte = b;
    item.last_byte = l;
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push    <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (full) @(posedge clk);
    unpack_filter_byte(b, l);
  endtask

  // I lsb..msb then Q lsb..msb; end mark optional on the sixth byte
  task automatic send_sample(input logic [23:0] i_raw, input logic [23:0] q_raw,
                             input logic l);
    int k;
    for (k = 0; k < 3; k++) send_byte(i_raw[8*k +: 8], 1'b0);
    for (k = 0; k < 3; k++) send_byte(q_raw[8*k +: 8], (k == 2) && l);
  endtask

  // drain all predicted items, then let the pipeline settle
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_iq.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  // register write; only called with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_ALPHA)
      m_alpha = val[COEF_W-1:0];
    else if (idx == REG_STOPPED)
      m_stopped = val[0];
    cfg_writes++;
    @(posedge clk);
  endtask

  // mostly uniform bytes, with a bias toward sign and full-scale patterns
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h7F;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // random stream: mostly whole samples, some cut short, some loose noise
  task automatic run_stream(input int target);
    int stop_at, kind, n, k;
    stop_at = stream_bytes + target;
    while (stream_bytes < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 80) begin
        // well-formed sample, end of buffer on the sixth byte now and then
        n = ($urandom_range(4) == 0);
        for (k = 0; k < 6; k++) send_byte(rand_byte(), (k == 5) && n);
      end else if (kind < 90) begin
        // buffer ends mid-sample
        n = $urandom_range(1, 5);
        for (k = 0; k < n; k++) send_byte(rand_byte(), k == n - 1);
      end else begin
        // noise: loose bytes with random end marks, may shift alignment
        n = $urandom_range(1, 8);
        for (k = 0; k < n; k++) send_byte(rand_byte(), $urandom_range(3) == 0);
      end
    end
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // all-zero sample (x sits at the -2^23 offset), then I at +full scale
  // and Q at -full scale with the end mark on the completing byte
  task automatic test_extreme_samples();
    send_sample(24'h000000, 24'h000000, 1'b0);
    send_sample(24'h7FFFFF, 24'h800000, 1'b1);
    wait_idle();
  endtask

  // end mark after two bytes, then after five: both samples vanish
  task automatic test_partial_drop();
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b0);
    send_byte(8'h05, 1'b1);
    wait_idle();
  endtask

  // stop in the middle of a sample; ignored bytes (end mark too) must not
  // disturb the two bytes already held
  task automatic test_stopped_hold();
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    wait_idle();
    write_reg(REG_STOPPED, CFG_DATA_W'(1));
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b1);
    wait_idle();
    write_reg(REG_STOPPED, CFG_DATA_W'(0));
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    wait_idle();
  endtask

  // alpha at full scale, slow receiver
  task automatic test_stream_slow_sink();
    send_idle_pct = 15;
    recv_idle_pct = 66;
    write_reg(REG_ALPHA, '1);
    run_stream(STREAM_BYTES);
  endtask

  // alpha zero (no feedback), slow sender
  task automatic test_stream_slow_source();
    send_idle_pct = 66;
    recv_idle_pct = 15;
    write_reg(REG_ALPHA, '0);
    run_stream(STREAM_BYTES);
  endtask

  // random alpha, no stalls on either side
  task automatic test_stream_full_rate();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_ALPHA, CFG_DATA_W'($urandom_range(24'hFFFFFF)));
    run_stream(STREAM_BYTES);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part runs at reset alpha with the first stall mix
    send_idle_pct = 15;
    recv_idle_pct = 66;
    test_extreme_samples();
    test_partial_drop();
    test_stopped_hold();

    test_stream_slow_sink();
    test_stream_slow_source();
    test_stream_full_rate();

    $display("run: %0d bytes filtered, %0d ignored while stopped, %0d partial samples dropped",
             stream_bytes, stopped_bytes, dropped_samples);
    $display("run: %0d I/Q items checked, %0d register writes, %0d mismatches",
             items_checked, cfg_writes, err_count);
    if (err_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== files.f =====
sv/iqdc_pkg.sv
sv/iqdc_fifo.sv
sv/iqdc_front.sv
sv/iqdc_back.sv
sv/iq24_unpack_dc_block.sv
tb/tb_iq24_unpack_dc_block.sv
